/* src/mbds_pkg.sv */
// Package for the mip box downsample block: widths, types, register map and
// the sRGB step threshold table built at elaboration.
// No dependencies.
`default_nettype none

package mbds_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int LINE_AW    = $clog2(LINE_DEPTH);

    localparam int CHAN_W  = 16;
    localparam int NCHAN   = 4;
    localparam int NCOLOR  = 3;
    localparam int PSUM_W  = CHAN_W + 1;
    localparam int SUM_W   = CHAN_W + 2;
    localparam int LINE_W  = 2 * PSUM_W;
    localparam int BYTE_W  = 8;
    localparam int WIDTH_REG_W  = 13;
    localparam int HEIGHT_REG_W = 16;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // register map (word index)
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SRGB   = 2'd2;

    // linear byte: (LIN_MUL*v + LIN_ADD) / (2*65535)
    localparam int LIN_X_W = 25;
    localparam int LIN_Y_W = LIN_X_W - 1;
    localparam logic [LIN_X_W-1:0] LIN_MUL = 25'd510;
    localparam logic [LIN_X_W-1:0] LIN_ADD = 25'd65535;

    typedef logic [NCHAN-1:0][CHAN_W-1:0] chan_vec_t;
    typedef logic [NCHAN-1:0][PSUM_W-1:0] psum_vec_t;
    typedef logic [NCHAN-1:0][BYTE_W-1:0] byte_vec_t;

    typedef struct packed {
        logic      last;
        logic      srgb;
        chan_vec_t v;
    } enc_pay_t;

    typedef struct packed {
        logic     valid;
        enc_pay_t pay;
    } enc_in_t;

    typedef struct packed {
        logic      valid;
        logic      last;
        chan_vec_t v;
        byte_vec_t bytes;
    } enc_out_t;

    // sRGB step thresholds: entry i is the smallest code whose byte exceeds i
    localparam int THR_W     = CHAN_W + 1;
    localparam int THR_COUNT = 256;
    localparam int SRCH_STEPS = $clog2(THR_COUNT);
    localparam int BIG_W     = 320;

    typedef logic [THR_W-1:0] thr_rom_t [THR_COUNT];
    typedef logic [BIG_W-1:0] big_t;

    function automatic big_t big_pow(big_t base, int e);
        big_t r;
        r = big_t'(1);
        for (int k = 0; k < e; k++)
            r = r * base;
        return r;
    endfunction

    function automatic logic byte_above(int unsigned v, int unsigned i, big_t lhs_k, big_t rhs);
        logic [63:0] v64;
        big_t        lhs;
        v64 = 64'(v);
        if (v64 * 64'd10000000 <= 64'd31308 * 64'd65535)
            return (v64 * 64'd1292 * 64'd510 >= 64'(2 * i + 1) * 64'd6553500);
        lhs = lhs_k * big_pow(big_t'(v), 5);
        return (lhs >= rhs);
    endfunction

    function automatic thr_rom_t build_thr_rom();
        thr_rom_t    t;
        big_t        k53;
        big_t        rhs;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        k53 = big_pow(big_t'(53805), 12);
        for (int i = 0; i < THR_COUNT - 1; i++)
        begin
            rhs = big_pow(big_t'(200 * i + 2905), 12) * big_pow(big_t'(65535), 5);
            lo  = 0;
            hi  = 65536;
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (byte_above(mid, i, k53, rhs))
                    hi = mid;
                else
                    lo = mid + 1;
            end
            t[i] = THR_W'(lo);
        end
        t[THR_COUNT-1] = THR_W'(65536);
        return t;
    endfunction

    localparam thr_rom_t THR_ROM = build_thr_rom();

endpackage

`default_nettype wire

/* src/mbds_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module mbds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* src/mbds_encode.sv */
// Byte encoder pipeline: linear rounding for all channels and an 8-step
// binary search of the sRGB threshold table for the colour channels.
// Depends on mbds_pkg.
`default_nettype none

module mbds_encode (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire mbds_pkg::enc_in_t in_item,
    output mbds_pkg::enc_out_t     out_item
);

    typedef struct packed {
        mbds_pkg::enc_pay_t                                            pay;
        logic [mbds_pkg::NCHAN-1:0][mbds_pkg::LIN_Y_W-1:0]             y;
    } e1_t;

    typedef struct packed {
        mbds_pkg::enc_pay_t  pay;
        mbds_pkg::byte_vec_t lin;
    } e2_t;

    typedef struct packed {
        mbds_pkg::enc_pay_t                                 pay;
        mbds_pkg::byte_vec_t                                lin;
        logic [mbds_pkg::NCOLOR-1:0][mbds_pkg::BYTE_W-1:0]  cnt;
    } srch_t;

    logic  e1_valid_reg;
    e1_t   e1_reg;
    e1_t   e1_next;
    logic  e2_valid_reg;
    e2_t   e2_reg;
    e2_t   e2_next;
    logic  [mbds_pkg::SRCH_STEPS-1:0] srch_valid_reg;
    srch_t srch_reg  [mbds_pkg::SRCH_STEPS];
    srch_t srch_next [mbds_pkg::SRCH_STEPS];

    always_comb
    begin
        logic [mbds_pkg::LIN_X_W-1:0] x;
        e1_next.pay = in_item.pay;
        for (int c = 0; c < mbds_pkg::NCHAN; c++)
        begin
            x = mbds_pkg::LIN_X_W'(in_item.pay.v[c]) * mbds_pkg::LIN_MUL + mbds_pkg::LIN_ADD;
            e1_next.y[c] = x[mbds_pkg::LIN_X_W-1:1];
        end
    end

    // divide by 65535: q = (y + (y >> 16) + 1) >> 16
    always_comb
    begin
        logic [mbds_pkg::LIN_Y_W-1:0] q;
        e2_next.pay = e1_reg.pay;
        for (int c = 0; c < mbds_pkg::NCHAN; c++)
        begin
            q = e1_reg.y[c] + (e1_reg.y[c] >> mbds_pkg::CHAN_W) + mbds_pkg::LIN_Y_W'(1);
            e2_next.lin[c] = q[mbds_pkg::LIN_Y_W-1:mbds_pkg::CHAN_W];
        end
    end

    always_comb
    begin
        srch_t src;
        srch_t nxt;
        logic [mbds_pkg::BYTE_W-1:0] idx;
        logic [mbds_pkg::BYTE_W-1:0] bitv;
        for (int k = 0; k < mbds_pkg::SRCH_STEPS; k++)
        begin
            if (k == 0)
            begin
                src.pay = e2_reg.pay;
                src.lin = e2_reg.lin;
                src.cnt = '0;
            end
            else
            begin
                src = srch_reg[k-1];
            end
            nxt  = src;
            bitv = mbds_pkg::BYTE_W'(1 << (mbds_pkg::SRCH_STEPS - 1 - k));
            for (int c = 0; c < mbds_pkg::NCOLOR; c++)
            begin
                idx = src.cnt[c] | (bitv - mbds_pkg::BYTE_W'(1));
                if (mbds_pkg::THR_ROM[idx] <= {1'b0, src.pay.v[c]})
                    nxt.cnt[c] = src.cnt[c] | bitv;
            end
            srch_next[k] = nxt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_valid_reg   <= 1'b0;
            e2_valid_reg   <= 1'b0;
            srch_valid_reg <= '0;
        end
        else if (adv)
        begin
            e1_valid_reg   <= in_item.valid;
            e2_valid_reg   <= e1_valid_reg;
            srch_valid_reg <= {srch_valid_reg[mbds_pkg::SRCH_STEPS-2:0], e2_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_reg <= e1_next;
            e2_reg <= e2_next;
            for (int k = 0; k < mbds_pkg::SRCH_STEPS; k++)
                srch_reg[k] <= srch_next[k];
        end
    end

    always_comb
    begin
        srch_t fin;
        fin            = srch_reg[mbds_pkg::SRCH_STEPS-1];
        out_item.valid = srch_valid_reg[mbds_pkg::SRCH_STEPS-1];
        out_item.last  = fin.pay.last;
        out_item.v     = fin.pay.v;
        for (int c = 0; c < mbds_pkg::NCHAN; c++)
        begin
            if (c < mbds_pkg::NCOLOR && fin.pay.srgb)
                out_item.bytes[c] = fin.cnt[c];
            else
                out_item.bytes[c] = fin.lin[c];
        end
    end

endmodule

`default_nettype wire

/* src/mip_box_downsample_srgb_core.sv */
// 2x2 box downsample of one mip level with linear / sRGB byte encode.
// Depends on mbds_pkg, mbds_ram, mbds_encode.
// Registers: r1, r2, the encoder stages e1, e2 and the search stages, then the
// output register. Throughput: one texel per cycle while the output is not blocked, set by
// the at most one line-store access (read or write) issued per accepted texel.
// Reset (rst_n, async low): counters, held texel, pipeline valids cleared;
// width and height 1, linear mode. The line store is not cleared.
`default_nettype none

module mip_box_downsample_srgb_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // s_axis_tdata: red_in, green_in, blue_in, alpha_in (16 bits each)
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [63:0]                   s_axis_tdata,
    // m_axis_tdata: red_out, green_out, blue_out, alpha_out (16 bits each),
    // red_byte, green_byte, blue_byte, alpha_byte (8 bits each)
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [95:0]                        m_axis_tdata,
    output logic                               m_axis_tlast,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mbds_pkg::APB_AW-1:0]   paddr,
    input  wire logic [mbds_pkg::APB_DW-1:0]   pwdata,
    output logic      [mbds_pkg::APB_DW-1:0]   prdata,
    output logic                               pready
);

    typedef struct packed {
        logic                use_mem;
        logic                last;
        logic                srgb;
        mbds_pkg::psum_vec_t p;
    } s1_t;

    // configuration
    logic [mbds_pkg::WIDTH_REG_W-1:0]  width_reg;
    logic [mbds_pkg::HEIGHT_REG_W-1:0] height_reg;
    logic                              srgb_reg;
    logic                              cfg_wr;
    logic                              cfg_hit;

    // counters and held texel
    logic [mbds_pkg::COL_W-1:0]        col_reg;
    logic [mbds_pkg::COL_W-1:0]        col_next;
    logic [mbds_pkg::HEIGHT_REG_W-1:0] row_reg;
    logic [mbds_pkg::HEIGHT_REG_W-1:0] row_next;
    mbds_pkg::chan_vec_t               held_reg;

    logic [mbds_pkg::WIDTH_REG_W-1:0]  w_eff;
    logic [mbds_pkg::HEIGHT_REG_W-1:0] h_eff;
    logic [mbds_pkg::COL_W-1:0]        col_eff;
    logic [mbds_pkg::HEIGHT_REG_W-1:0] row_eff;
    logic                              w_one;
    logic                              h_one;
    logic                              col_wrap;
    logic                              have;
    logic                              load_held;
    logic                              emit;
    logic                              use_mem;
    logic                              do_write;
    logic                              is_last;
    logic [mbds_pkg::LINE_AW-1:0]      ox;
    logic [mbds_pkg::COL_W-1:0]        ow;
    logic [mbds_pkg::HEIGHT_REG_W-1:0] oh;
    mbds_pkg::chan_vec_t               tin;
    mbds_pkg::psum_vec_t               p;

    logic                              acc;
    logic                              adv;
    logic                              out_load;

    // line store
    logic                              ram_wr_en;
    logic                              ram_rd_en;
    logic [mbds_pkg::LINE_W-1:0]       rg_wdata;
    logic [mbds_pkg::LINE_W-1:0]       ba_wdata;
    logic [mbds_pkg::LINE_W-1:0]       rg_rdata;
    logic [mbds_pkg::LINE_W-1:0]       ba_rdata;

    // pipeline
    logic                              r1_valid_reg;
    s1_t                               r1_reg;
    s1_t                               r1_next;
    logic                              r2_valid_reg;
    mbds_pkg::enc_pay_t                r2_reg;
    mbds_pkg::enc_pay_t                r2_next;
    mbds_pkg::enc_in_t                 enc_in;
    mbds_pkg::enc_out_t                enc_out;

    logic                              out_valid_reg;
    logic                              out_last_reg;
    mbds_pkg::chan_vec_t               out_v_reg;
    mbds_pkg::byte_vec_t               out_bytes_reg;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[3:2])
            mbds_pkg::REG_WIDTH:  cfg_hit = cfg_wr;
            mbds_pkg::REG_HEIGHT: cfg_hit = cfg_wr;
            mbds_pkg::REG_SRGB:   cfg_hit = cfg_wr;
            default:              cfg_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        case (paddr[3:2])
            mbds_pkg::REG_WIDTH:  prdata = mbds_pkg::APB_DW'(width_reg);
            mbds_pkg::REG_HEIGHT: prdata = mbds_pkg::APB_DW'(height_reg);
            mbds_pkg::REG_SRGB:   prdata = mbds_pkg::APB_DW'(srgb_reg);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= mbds_pkg::WIDTH_REG_W'(1);
            height_reg <= mbds_pkg::HEIGHT_REG_W'(1);
            srgb_reg   <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                mbds_pkg::REG_WIDTH:  width_reg  <= pwdata[mbds_pkg::WIDTH_REG_W-1:0];
                mbds_pkg::REG_HEIGHT: height_reg <= pwdata[mbds_pkg::HEIGHT_REG_W-1:0];
                mbds_pkg::REG_SRGB:   srgb_reg   <= pwdata[0];
                default:              ;
            endcase
        end
    end

    // ---------------- input stage ----------------
    assign tin = s_axis_tdata;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = mbds_pkg::WIDTH_REG_W'(1);
        else if (width_reg > mbds_pkg::WIDTH_REG_W'(mbds_pkg::MAX_WIDTH))
            w_eff = mbds_pkg::WIDTH_REG_W'(mbds_pkg::MAX_WIDTH);
        else
            w_eff = width_reg;
        h_eff   = (height_reg == '0) ? mbds_pkg::HEIGHT_REG_W'(1) : height_reg;
        col_eff = ({1'b0, col_reg} >= w_eff) ? '0 : col_reg;
        row_eff = (row_reg >= h_eff) ? '0 : row_reg;
        w_one   = (w_eff == mbds_pkg::WIDTH_REG_W'(1));
        h_one   = (h_eff == mbds_pkg::HEIGHT_REG_W'(1));

        col_wrap = ({1'b0, col_eff} + mbds_pkg::WIDTH_REG_W'(1)) >= w_eff;
        col_next = col_wrap ? '0 : col_eff + mbds_pkg::COL_W'(1);
        if (col_wrap)
            row_next = ({1'b0, row_eff} + 17'd1 >= {1'b0, h_eff}) ? '0
                     : row_eff + mbds_pkg::HEIGHT_REG_W'(1);
        else
            row_next = row_eff;

        have      = w_one || col_eff[0];
        load_held = !w_one && !col_eff[0] && !col_wrap;
        ox        = col_eff[mbds_pkg::COL_W-1:1];
        for (int c = 0; c < mbds_pkg::NCHAN; c++)
        begin
            if (w_one)
                p[c] = {tin[c], 1'b0};
            else
                p[c] = mbds_pkg::PSUM_W'(held_reg[c]) + mbds_pkg::PSUM_W'(tin[c]);
        end

        use_mem  = !h_one && row_eff[0];
        emit     = have && (h_one || row_eff[0]);
        do_write = have && !h_one && !row_eff[0]
                && ({1'b0, row_eff} + 17'd1 < {1'b0, h_eff});

        ow = w_one ? mbds_pkg::COL_W'(1) : w_eff[mbds_pkg::COL_W:1];
        oh = h_one ? mbds_pkg::HEIGHT_REG_W'(1) : {1'b0, h_eff[mbds_pkg::HEIGHT_REG_W-1:1]};
        is_last = (mbds_pkg::COL_W'(ox) == ow - mbds_pkg::COL_W'(1))
               && ({1'b0, row_eff[mbds_pkg::HEIGHT_REG_W-1:1]} == oh - mbds_pkg::HEIGHT_REG_W'(1));
    end

    assign out_load      = !out_valid_reg || m_axis_tready;
    assign adv           = out_load || !enc_out.valid;
    assign s_axis_tready = adv;
    assign acc           = s_axis_tvalid && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            held_reg <= '0;
        end
        else if (cfg_hit)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (load_held)
                held_reg <= tin;
        end
    end

    // ---------------- line store ----------------
    // At most one access per accepted texel; an odd row reads an entry in a later
    // transaction than the one in which the even row wrote it, so no forwarding is needed.
    assign ram_wr_en = acc && do_write;
    assign ram_rd_en = acc && have && use_mem;
    assign rg_wdata  = {p[1], p[0]};
    assign ba_wdata  = {p[3], p[2]};

    mbds_ram #(
        .WIDTH (mbds_pkg::LINE_W),
        .DEPTH (mbds_pkg::LINE_DEPTH)
    ) u_line_rg (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ox),
        .wr_data (rg_wdata),
        .rd_en   (ram_rd_en),
        .rd_addr (ox),
        .rd_data (rg_rdata)
    );

    mbds_ram #(
        .WIDTH (mbds_pkg::LINE_W),
        .DEPTH (mbds_pkg::LINE_DEPTH)
    ) u_line_ba (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ox),
        .wr_data (ba_wdata),
        .rd_en   (ram_rd_en),
        .rd_addr (ox),
        .rd_data (ba_rdata)
    );

    // ---------------- vertical sum and average ----------------
    always_comb
    begin
        r1_next.use_mem = use_mem;
        r1_next.last    = is_last;
        r1_next.srgb    = srgb_reg;
        r1_next.p       = p;
    end

    always_comb
    begin
        logic [mbds_pkg::NCHAN-1:0][mbds_pkg::PSUM_W-1:0] upper;
        logic [mbds_pkg::SUM_W-1:0] s;
        upper = {ba_rdata, rg_rdata};
        r2_next.last = r1_reg.last;
        r2_next.srgb = r1_reg.srgb;
        for (int c = 0; c < mbds_pkg::NCHAN; c++)
        begin
            if (r1_reg.use_mem)
                s = mbds_pkg::SUM_W'(upper[c]) + mbds_pkg::SUM_W'(r1_reg.p[c]);
            else
                s = {r1_reg.p[c], 1'b0};
            s = s + mbds_pkg::SUM_W'(2);
            r2_next.v[c] = s[mbds_pkg::SUM_W-1:2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_valid_reg <= 1'b0;
            r2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            r1_valid_reg <= acc && emit;
            r2_valid_reg <= r1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_reg <= r1_next;
            r2_reg <= r2_next;
        end
    end

    // ---------------- encode ----------------
    assign enc_in.valid = r2_valid_reg;
    assign enc_in.pay   = r2_reg;

    mbds_encode u_encode (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_item  (enc_in),
        .out_item (enc_out)
    );

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= enc_out.valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_last_reg  <= enc_out.last;
            out_v_reg     <= enc_out.v;
            out_bytes_reg <= enc_out.bytes;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_bytes_reg, out_v_reg};
    assign m_axis_tlast  = out_last_reg;

    // ---------------- assertions ----------------
    a_stall_only_on_full_out: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a blocked result");

    a_line_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_wr_en && ram_rd_en))
        else $error("line store read and write in one cycle");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, col_reg} < w_eff)
        else $error("column counter beyond width");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg < h_eff)
        else $error("row counter beyond height");

endmodule

`default_nettype wire
